[rtl/core/bfl_pkg.sv]
// shared types, widths and codes of the block free list allocator
`timescale 1ns / 1ps

package bfl_pkg;

    localparam int BLK_W  = 10;
    localparam int CFG_W  = 11;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;
    localparam int OP_W   = 3;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // blocks in the largest volume, link memory depth
    localparam int MAX_BLOCKS = 1024;

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_FORMAT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP     = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd2;

    // classified operations passed from front to back
    localparam logic [OP_W-1:0] OP_FORMAT  = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [OP_W-1:0] OP_INVALID = 3'd3;
    localparam logic [OP_W-1:0] OP_NOP     = 3'd4;

    // register index (paddr bit 2)
    localparam logic REG_BLOCK_COUNT = 1'b0;

    localparam logic [CFG_W-1:0] BLOCK_COUNT_RESET = 11'd1024;

    typedef logic [BLK_W-1:0] blk_t;
    typedef logic [CFG_W-1:0] cnt_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        blk_t            blk;
    } cmd_t;

    typedef struct packed {
        blk_t              granted;
        blk_t              free;
        logic [STAT_W-1:0] status;
    } res_t;

    // block count clamped to 1 .. MAX_BLOCKS
    function automatic cnt_t eff_count(input cnt_t bc);
        cnt_t n;
        n = bc;
        if (bc == '0) begin
            n = 11'd1;
        end
        else if (32'(bc) > MAX_BLOCKS) begin
            n = CFG_W'(MAX_BLOCKS);
        end
        return n;
    endfunction

endpackage

[rtl/core/bfl_front.sv]
// front stage: takes requests and classifies them into operations
`timescale 1ns / 1ps

module bfl_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [bfl_pkg::FUNC_W-1:0] func,
    input  bfl_pkg::blk_t              block_index,
    input  bfl_pkg::cnt_t              eff_n,
    input  logic                       q_full,
    output logic                       q_wr,
    output bfl_pkg::cmd_t              q_cmd
);

    logic          valid_reg;
    logic          valid_next;
    bfl_pkg::cmd_t cmd_reg;
    bfl_pkg::cmd_t cmd_next;
    logic          accept;

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_wr   = valid_reg && !q_full;
    assign q_cmd  = cmd_reg;

    always_comb
    begin
        cmd_next     = cmd_reg;
        cmd_next.blk = block_index;
        unique case (func)
            bfl_pkg::FUNC_FORMAT:  cmd_next.op = bfl_pkg::OP_FORMAT;
            bfl_pkg::FUNC_ALLOC:   cmd_next.op = bfl_pkg::OP_ALLOC;
            bfl_pkg::FUNC_RELEASE:
            begin
                // reserved block or beyond the volume
                if (block_index == '0 || {1'b0, block_index} >= eff_n) begin
                    cmd_next.op = bfl_pkg::OP_INVALID;
                end
                else begin
                    cmd_next.op = bfl_pkg::OP_RELEASE;
                end
            end
            bfl_pkg::FUNC_NOP:     cmd_next.op = bfl_pkg::OP_NOP;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end
        else if (q_wr) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

[rtl/core/bfl_queue.sv]
// two-entry operation queue between front and back
`timescale 1ns / 1ps

module bfl_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  bfl_pkg::cmd_t wr_cmd,
    output logic          q_full,
    input  logic          rd,
    output logic          q_empty,
    output bfl_pkg::cmd_t rd_cmd
);

    bfl_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign rd_cmd  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr;
        rd_ptr_next = rd_ptr_reg ^ rd;
        count_next  = count_reg;
        if (wr && !rd) begin
            count_next = count_reg + 2'd1;
        end
        else if (rd && !wr) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

[rtl/core/bfl_back.sv]
// back end: link memory, list head, free count and result register
`timescale 1ns / 1ps

module bfl_back (
    input  logic          clk,
    input  logic          rst_n,
    input  bfl_pkg::cnt_t eff_n,
    input  logic          cmd_valid,
    input  bfl_pkg::cmd_t cmd,
    output logic          cmd_take,
    output logic          res_valid,
    output bfl_pkg::res_t res,
    input  logic          res_pop
);

    localparam int AW = $clog2(bfl_pkg::MAX_BLOCKS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FMT   = 2'd1;
    localparam logic [1:0] ST_ALLOC = 2'd2;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    bfl_pkg::blk_t head_reg;
    bfl_pkg::blk_t head_next;
    bfl_pkg::blk_t free_reg;
    bfl_pkg::blk_t free_next;
    bfl_pkg::cnt_t idx_reg;
    bfl_pkg::cnt_t idx_next;
    bfl_pkg::cnt_t idx_plus;
    logic          out_valid_reg;
    logic          out_valid_next;
    bfl_pkg::res_t out_reg;
    bfl_pkg::res_t out_next;
    logic          take_ok;

    bfl_pkg::blk_t link_mem [bfl_pkg::MAX_BLOCKS];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    bfl_pkg::blk_t mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    bfl_pkg::blk_t rd_data_reg;

    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign take_ok   = !out_valid_reg || res_pop;
    assign idx_plus  = idx_reg + 11'd1;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        free_next      = free_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !res_pop;
        out_next       = out_reg;
        cmd_take       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = AW'(head_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && take_ok) begin
                    cmd_take         = 1'b1;
                    out_next.granted = '0;
                    out_next.status  = bfl_pkg::STATUS_OK;
                    unique case (cmd.op)
                        bfl_pkg::OP_FORMAT:
                        begin
                            if (eff_n > 11'd1) begin
                                idx_next   = 11'd1;
                                state_next = ST_FMT;
                            end
                            else begin
                                // single-block volume: list stays empty
                                head_next      = '0;
                                free_next      = '0;
                                out_next.free  = '0;
                                out_valid_next = 1'b1;
                            end
                        end
                        bfl_pkg::OP_ALLOC:
                        begin
                            if (head_reg == '0) begin
                                out_next.free   = free_reg;
                                out_next.status = bfl_pkg::STATUS_FULL;
                                out_valid_next  = 1'b1;
                            end
                            else begin
                                mem_re     = 1'b1;
                                state_next = ST_ALLOC;
                            end
                        end
                        bfl_pkg::OP_RELEASE:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(cmd.blk);
                            mem_wdata = head_reg;
                            head_next = cmd.blk;
                            if ({1'b0, free_reg} < eff_n - 11'd1) begin
                                free_next = free_reg + 10'd1;
                            end
                            out_next.free  = free_next;
                            out_valid_next = 1'b1;
                        end
                        bfl_pkg::OP_INVALID:
                        begin
                            out_next.free   = free_reg;
                            out_next.status = bfl_pkg::STATUS_INVALID;
                            out_valid_next  = 1'b1;
                        end
                        default:
                        begin
                            out_next.free  = free_reg;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_FMT:
            begin
                // one link per cycle, last block ends the chain
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_reg);
                mem_wdata = (idx_plus < eff_n) ? idx_plus[bfl_pkg::BLK_W-1:0] : '0;
                idx_next  = idx_plus;
                if (idx_plus == eff_n) begin
                    head_next        = 10'd1;
                    free_next        = idx_reg[bfl_pkg::BLK_W-1:0];
                    out_next.granted = '0;
                    out_next.free    = free_next;
                    out_next.status  = bfl_pkg::STATUS_OK;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_ALLOC:
            begin
                head_next = rd_data_reg;
                if (free_reg != '0) begin
                    free_next = free_reg - 10'd1;
                end
                out_next.granted = head_reg;
                out_next.free    = free_next;
                out_next.status  = bfl_pkg::STATUS_OK;
                out_valid_next   = 1'b1;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            free_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re) begin
            rd_data_reg <= link_mem[mem_raddr];
        end
    end

endmodule

[rtl/core/block_free_list_allocator_top.sv]
// top level of the linked free list block allocator
`timescale 1ns / 1ps

//  channel   direction  handshake                      payload
//  request   in         push / full                    func, block_index
//  result    out        empty / pop                    granted_block, free_blocks, status
//  config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
//  back end per request: release, refused release and no-op are done in the idle state,
//  allocate does one registered link-memory read before the head moves,
//  format writes one link per cycle to blocks 1 .. n-1, n = clamped block count
//  requests pass the front register and the operation queue ahead of the back end
//  rst_n is asynchronous; head and free count clear, block_count returns to 1024,
//  link memory is not cleared and is only read where format or release wrote it
//  a full result register stalls the back end; the queue lets the front keep taking

module block_free_list_allocator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        push,
    output logic                        full,
    input  logic [bfl_pkg::FUNC_W-1:0]  func,
    input  logic [bfl_pkg::BLK_W-1:0]   block_index,
    // result channel
    output logic                        empty,
    input  logic                        pop,
    output logic [bfl_pkg::BLK_W-1:0]   granted_block,
    output logic [bfl_pkg::BLK_W-1:0]   free_blocks,
    output logic [bfl_pkg::STAT_W-1:0]  status,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bfl_pkg::ADDR_W-1:0]  paddr,
    input  logic [bfl_pkg::DATA_W-1:0]  pwdata,
    output logic [bfl_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    bfl_pkg::cnt_t block_count_reg;
    bfl_pkg::cnt_t block_count_next;
    bfl_pkg::cnt_t eff_n;
    logic          cfg_wr;

    logic          q_wr;
    bfl_pkg::cmd_t q_wr_cmd;
    logic          q_full;
    logic          q_empty;
    bfl_pkg::cmd_t q_rd_cmd;
    logic          cmd_take;

    logic          res_valid;
    bfl_pkg::res_t res;
    logic          res_pop;

    // register file: block_count at byte address 0, bit 2 picks the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        block_count_next = block_count_reg;
        if (cfg_wr && paddr[2] == bfl_pkg::REG_BLOCK_COUNT) begin
            block_count_next = pwdata[bfl_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            block_count_reg <= bfl_pkg::BLOCK_COUNT_RESET;
        end
        else begin
            block_count_reg <= block_count_next;
        end
    end

    assign prdata = (paddr[2] == bfl_pkg::REG_BLOCK_COUNT) ?
                    bfl_pkg::DATA_W'(block_count_reg) : '0;

    // effective block count, clamped to the memory depth and at least one
    assign eff_n = bfl_pkg::eff_count(block_count_reg);

    // front: request register and release range check
    bfl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .func        (func),
        .block_index (block_index),
        .eff_n       (eff_n),
        .q_full      (q_full),
        .q_wr        (q_wr),
        .q_cmd       (q_wr_cmd)
    );

    // decoupling queue
    bfl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_cmd  (q_wr_cmd),
        .q_full  (q_full),
        .rd      (cmd_take),
        .q_empty (q_empty),
        .rd_cmd  (q_rd_cmd)
    );

    // back: list operations and result register
    bfl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff_n     (eff_n),
        .cmd_valid (!q_empty),
        .cmd       (q_rd_cmd),
        .cmd_take  (cmd_take),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (res_pop)
    );

    assign empty         = !res_valid;
    assign res_pop       = pop && res_valid;
    assign granted_block = res.granted;
    assign free_blocks   = res.free;
    assign status        = res.status;

endmodule
